// ===== rtl/mpc_pkg.sv =====
// Package for the stream header parser: beat types, state codes, magic constants.
// Used by every module under rtl; no dependencies.
package mpc_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic        first;
  } mpc_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  foreign_kind;
    logic [9:0]  stream_version;
    logic [31:0] total_frames;
    logic [15:0] sample_rate;
    logic [7:0]  profile;
    logic [7:0]  encoder;
    logic [8:0]  coded_bitrate;
    logic [5:0]  max_band;
    logic [1:0]  stereo_modes;
    logic [15:0] last_valid_samples;
    logic [28:0] skip_bytes;
  } mpc_out_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_ID3  = 3'd1,
    KIND_SV46 = 3'd2,
    KIND_SV7  = 3'd3,
    KIND_SV7F = 3'd4
  } mpc_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WAIT = 2'd1,
    ST_EXEC = 2'd2,
    ST_OUT  = 2'd3
  } mpc_state_e;

  localparam logic [3:0] STAT_SV46    = 4'd0;
  localparam logic [3:0] STAT_SV7     = 4'd1;
  localparam logic [3:0] STAT_SV7F    = 4'd2;
  localparam logic [3:0] STAT_ID3     = 4'd3;
  localparam logic [3:0] STAT_BAD_ID3 = 4'd4;
  localparam logic [3:0] STAT_FOREIGN = 4'd5;
  localparam logic [3:0] STAT_NEWER   = 4'd6;
  localparam logic [3:0] STAT_NOT_MPC = 4'd7;
  localparam logic [3:0] STAT_BLKSIZE = 4'd8;

  localparam logic [3:0] FOREIGN_AC3 = 4'd13;

  localparam logic [31:0] ForeignMagic [12] = '{
    32'h2043414D, 32'h7961722E, 32'h46464952, 32'h43614C66,
    32'h4341504C, 32'h37414B52, 32'h676B6A61, 32'h040A5A53,
    32'h5367674F, 32'h46494441, 32'h75B22630, 32'hBA010000
  };

  localparam logic [15:0] RateTable [4] = '{16'd44100, 16'd48000, 16'd37800, 16'd32000};

  // command from controller to datapath
  typedef struct packed {
    logic load;   // capture input beat
    logic exec;   // run parse step on captured beat
    logic pop;    // result taken
  } mpc_cmd_t;

  typedef struct packed {
    logic emit;   // last exec produced a verdict
  } mpc_sts_t;

endpackage

// ===== rtl/mpc_stream_header_parser_core.sv =====
// Top level of the stream header parser: controller plus datapath.
// Depends on mpc_pkg, mpc_ctrl, mpc_datapath.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_beat_i  (mpc_in_t)
//   out     | output    | out_valid/out_stall| out_beat_o (mpc_out_t)
//
// Each input beat passes through capture, parse step and verdict check;
// a beat that completes a verdict then waits in the result handoff until it is taken.
// Reset returns to idle; words without first are ignored until a first beat.
// Input stalls while a beat is in work or a result waits.
module mpc_stream_header_parser_core import mpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mpc_in_t  in_beat_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mpc_out_t out_beat_o
);

  mpc_cmd_t cmd;
  mpc_sts_t sts;

  mpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mpc_datapath u_dp (
    .clk_i, .rst_ni, .beat_i(in_beat_i), .cmd_i(cmd), .sts_o(sts), .res_o(out_beat_o)
  );

endmodule

// ===== rtl/mpc_datapath.sv =====
// Datapath: captured beat, field registers and the per-word parse step.
// Depends on mpc_pkg.
module mpc_datapath import mpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mpc_in_t  beat_i,
  input  mpc_cmd_t cmd_i,
  output mpc_sts_t sts_o,
  output mpc_out_t res_o
);

  mpc_in_t   beat_q;
  logic      done_q, done_d;
  logic [5:0] step_q, step_d;
  mpc_kind_e kind_q, kind_d;
  mpc_out_t  f_q, f_d;
  logic      emit_d, emit_q;

  logic [31:0] w;
  logic [7:0]  top;
  logic [9:0]  sv;
  logic        run;
  logic [3:0]  fmatch;
  logic        fhit;
  logic [28:0] acc;

  assign w   = beat_q.word;
  assign top = w[31:24];
  assign sv  = w[20:11];

  always_comb begin
    fhit   = 1'b0;
    fmatch = 4'd0;
    for (int i = 0; i < 12; i++) begin
      if (!fhit && w == ForeignMagic[i]) begin
        fhit   = 1'b1;
        fmatch = 4'(i + 1);
      end
    end
  end

  always_comb begin
    f_d    = f_q;
    kind_d = kind_q;
    step_d = step_q;
    done_d = done_q;
    emit_d = 1'b0;
    acc    = f_q.skip_bytes;
    run    = 1'b0;
    if (cmd_i.exec) begin
      if (beat_q.first) begin
        f_d         = '0;
        f_d.profile = 8'hFF;
        kind_d      = KIND_NONE;
        step_d      = '0;
        done_d      = 1'b0;
        run         = 1'b1;
      end else begin
        run = !done_q;
      end
    end
    if (run) begin
      if (step_d == 6'd0) begin
        if (w[23:0] == 24'h334449 && top >= 8'd1 && top <= 8'd4) begin
          kind_d       = KIND_ID3;
          f_d.skip_bytes = 29'd10;
        end else if (w == 32'h072B504D || w == 32'h172B504D ||
                     w == 32'hF72B504D || w == 32'hFF2B504D) begin
          kind_d = (top[7:4] == 4'hF) ? KIND_SV7F : KIND_SV7;
          f_d.stream_version = {2'b00, top};
        end else if (fhit) begin
          f_d.status = STAT_FOREIGN; f_d.foreign_kind = fmatch; emit_d = 1'b1;
        end else if (w[23:0] == 24'h2B504D) begin
          f_d.stream_version = {2'b00, top};
          f_d.status = STAT_NEWER; emit_d = 1'b1;
        end else if (w[15:0] == 16'h770B) begin
          f_d.status = STAT_FOREIGN; f_d.foreign_kind = FOREIGN_AC3; emit_d = 1'b1;
        end else begin
          f_d.stream_version = sv;
          if (sv < 10'd4 || sv > 10'd6) begin
            f_d.status = STAT_NOT_MPC; emit_d = 1'b1;
          end else begin
            f_d.coded_bitrate = w[31:23];
            f_d.max_band      = {1'b0, w[10:6]};
            f_d.stereo_modes  = {w[22], w[21]};
            if (w[5:0] != 6'd1) begin
              f_d.status = STAT_BLKSIZE; emit_d = 1'b1;
            end else begin
              f_d.sample_rate = 16'd44100;
              kind_d = KIND_SV46;
            end
          end
        end
      end else begin
        unique case (kind_q)
          KIND_ID3: begin
            if (step_q == 6'd1) begin
              if (w[31] || w[23]) begin
                f_d.status = STAT_BAD_ID3; emit_d = 1'b1;
              end else begin
                acc = acc + (29'(w[30:24]) << 14) + (29'(w[22:16]) << 21)
                          + (w[14] ? 29'd10 : 29'd0);
                f_d.skip_bytes = acc;
              end
            end else begin
              if (w[15] || w[7]) begin
                f_d.status = STAT_BAD_ID3; emit_d = 1'b1;
              end else begin
                f_d.skip_bytes = acc + 29'(w[14:8]) + (29'(w[6:0]) << 7);
                f_d.status = STAT_ID3; emit_d = 1'b1;
              end
            end
          end
          KIND_SV46: begin
            f_d.total_frames = (f_q.stream_version < 10'd5) ? {16'd0, w[31:16]} : w;
            f_d.status = STAT_SV46; emit_d = 1'b1;
          end
          KIND_SV7: begin
            unique case (step_q)
              6'd1: f_d.total_frames = w;
              6'd2: begin
                f_d.stereo_modes = {w[31], w[30]};
                f_d.max_band     = w[29:24];
                f_d.profile      = {4'd0, w[23:20]};
                f_d.sample_rate  = RateTable[w[17:16]];
              end
              6'd5: f_d.last_valid_samples = {5'd0, w[30:20]};
              6'd6: begin
                f_d.encoder = w[31:24];
                f_d.status  = STAT_SV7; emit_d = 1'b1;
              end
              default: ;
            endcase
          end
          KIND_SV7F: begin
            unique case (step_q)
              6'd1: begin
                f_d.profile = w[15:8];
                f_d.encoder = w[7:0];
              end
              6'd2: f_d.total_frames = w;
              6'd5: begin
                f_d.max_band           = w[31:26];
                f_d.stereo_modes       = {1'b0, w[25]};
                f_d.last_valid_samples = w[15:0];
              end
              6'd7: begin
                f_d.sample_rate = w[31:16];
                f_d.status = STAT_SV7F; emit_d = 1'b1;
              end
              default: ;
            endcase
          end
          default: done_d = 1'b1;
        endcase
      end
      if (emit_d) done_d = 1'b1;
      if (!done_d) step_d = step_d + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b1;
      step_q <= '0;
      kind_q <= KIND_NONE;
      emit_q <= 1'b0;
      f_q    <= '0;
    end else begin
      done_q <= done_d;
      step_q <= step_d;
      kind_q <= kind_d;
      emit_q <= cmd_i.exec ? emit_d : (cmd_i.pop ? 1'b0 : emit_q);
      f_q    <= f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) beat_q <= beat_i;
  end

  assign sts_o.emit = emit_q;
  assign res_o      = f_q;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q |-> step_q <= 6'd7) else $error("step overrun");
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && emit_d |=> done_q) else $error("verdict without done");
  a_kind_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_q && step_q != 6'd0) |-> kind_q != KIND_NONE) else $error("kind lost");
`endif

endmodule

// ===== rtl/mpc_ctrl.sv =====
// Controller: sequences capture, parse step and result handoff per beat.
// Depends on mpc_pkg.
module mpc_ctrl import mpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  mpc_sts_t sts_i,
  output mpc_cmd_t cmd_o
);

  mpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = sts_i.emit ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept during output");
  a_exec_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.exec) else $error("load not followed by exec");
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(sts_i.emit)) else $error("spurious result");
`endif

endmodule

// ===== test/tb_mpc_stream_header_parser_core.sv =====
// Testbench for mpc_stream_header_parser_core: directed headers, then random files.
// Verdicts are predicted by an in-bench header parser; depends on mpc_pkg and the RTL.
`timescale 1ns / 1ps
module tb_mpc_stream_header_parser_core;
  import mpc_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  mpc_in_t  in_beat_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  mpc_out_t out_beat_o;

  mpc_stream_header_parser_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // header parser state
  logic [31:0] hp_word;
  int          hp_pos;
  int          hp_step;
  mpc_kind_e   hp_kind;
  logic        hp_done;
  mpc_out_t    hp_f;

  mpc_out_t verdict_q[$];
  int       errors = 0;
  int       verdicts_seen = 0;
  int       words_sent = 0;
  bit       hold_long = 1'b0;

  function automatic logic [31:0] take_bits(int n);
    logic [31:0] v;
    if (hp_pos + n > 32) return '0;
    v = 32'((64'(hp_word) >> (32 - hp_pos - n)) & ((64'd1 << n) - 64'd1));
    hp_pos += n;
    return v;
  endfunction

  function automatic void post_verdict(logic [3:0] st, logic [3:0] fk);
    mpc_out_t r;
    r = hp_f;
    r.status = st;
    r.foreign_kind = fk;
    verdict_q.push_back(r);
    hp_done = 1'b1;
  endfunction

  function automatic void parse_lead(logic [31:0] w);
    logic [7:0] top;
    logic [9:0] sv;
    logic       is_b, ms_b;
    top = w[31:24];
    if (w[23:0] == 24'h334449 && top >= 1 && top <= 4) begin
      hp_kind = KIND_ID3;
      hp_f.skip_bytes = 29'd10;
      return;
    end
    if (w == 32'h072B504D || w == 32'h172B504D || w == 32'hF72B504D ||
        w == 32'hFF2B504D) begin
      hp_kind = (top[7:4] == 4'hF) ? KIND_SV7F : KIND_SV7;
      hp_f.stream_version = {2'b00, top};
      return;
    end
    for (int i = 0; i < 12; i++)
      if (w == ForeignMagic[i]) begin
        post_verdict(STAT_FOREIGN, 4'(i + 1));
        return;
      end
    if (w[23:0] == 24'h2B504D) begin
      hp_f.stream_version = {2'b00, top};
      post_verdict(STAT_NEWER, '0);
      return;
    end
    if (w[15:0] == 16'h770B) begin
      post_verdict(STAT_FOREIGN, FOREIGN_AC3);
      return;
    end
    sv = w[20:11];
    hp_f.stream_version = sv;
    if (sv < 4 || sv > 6) begin
      post_verdict(STAT_NOT_MPC, '0);
      return;
    end
    hp_f.coded_bitrate = 9'(take_bits(9));
    is_b = 1'(take_bits(1));
    ms_b = 1'(take_bits(1));
    void'(take_bits(10));
    hp_f.max_band = 6'(take_bits(5));
    hp_f.stereo_modes = {is_b, ms_b};
    if (take_bits(6) != 1) begin
      post_verdict(STAT_BLKSIZE, '0);
      return;
    end
    hp_f.sample_rate = 16'd44100;
    hp_kind = KIND_SV46;
  endfunction

  function automatic void parse_id3_word();
    logic [31:0] acc;
    acc = 32'(hp_f.skip_bytes);
    if (hp_step == 1) begin
      if (take_bits(1)) begin post_verdict(STAT_BAD_ID3, '0); return; end
      acc += take_bits(7) << 14;
      if (take_bits(1)) begin post_verdict(STAT_BAD_ID3, '0); return; end
      acc += take_bits(7) << 21;
      void'(take_bits(1));
      if (take_bits(1)) acc += 10;
      hp_f.skip_bytes = acc[28:0];
      return;
    end
    void'(take_bits(16));
    if (take_bits(1)) begin post_verdict(STAT_BAD_ID3, '0); return; end
    acc += take_bits(7);
    if (take_bits(1)) begin post_verdict(STAT_BAD_ID3, '0); return; end
    acc += take_bits(7) << 7;
    hp_f.skip_bytes = acc[28:0];
    post_verdict(STAT_ID3, '0);
  endfunction

  function automatic void parse_sv7_word(logic [31:0] w);
    logic is_b, ms_b;
    case (hp_step)
      1: hp_f.total_frames = w;
      2: begin
        is_b = 1'(take_bits(1));
        ms_b = 1'(take_bits(1));
        hp_f.stereo_modes = {is_b, ms_b};
        hp_f.max_band = 6'(take_bits(6));
        hp_f.profile = 8'(take_bits(4));
        void'(take_bits(2));
        hp_f.sample_rate = RateTable[2'(take_bits(2))];
      end
      5: begin
        void'(take_bits(1));
        hp_f.last_valid_samples = 16'(take_bits(11));
      end
      6: begin
        hp_f.encoder = 8'(take_bits(8));
        post_verdict(STAT_SV7, '0);
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_sv7f_word(logic [31:0] w);
    case (hp_step)
      1: begin
        void'(take_bits(16));
        hp_f.profile = 8'(take_bits(8));
        hp_f.encoder = 8'(take_bits(8));
      end
      2: hp_f.total_frames = w;
      5: begin
        hp_f.max_band = 6'(take_bits(6));
        hp_f.stereo_modes = 2'(take_bits(1));
        void'(take_bits(9));
        hp_f.last_valid_samples = 16'(take_bits(16));
      end
      7: begin
        hp_f.sample_rate = 16'(take_bits(16));
        post_verdict(STAT_SV7F, '0);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_word(mpc_in_t b);
    if (b.first) begin
      hp_f = '0;
      hp_f.profile = 8'hFF;
      hp_kind = KIND_NONE;
      hp_step = 0;
      hp_done = 1'b0;
    end else if (hp_done) begin
      return;
    end
    hp_word = b.word;
    hp_pos = 0;
    if (hp_step == 0) parse_lead(b.word);
    else begin
      case (hp_kind)
        KIND_ID3: parse_id3_word();
        KIND_SV46: begin
          hp_f.total_frames = (hp_f.stream_version < 5) ? take_bits(16) : b.word;
          post_verdict(STAT_SV46, '0);
        end
        KIND_SV7: parse_sv7_word(b.word);
        KIND_SV7F: parse_sv7f_word(b.word);
        default: hp_done = 1'b1;
      endcase
    end
    if (!hp_done) hp_step = (hp_step + 1) & 63;
  endfunction

  // gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(logic [31:0] w, logic f);
    int g;
    g = gap_len();
    repeat (g) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= '{word: w, first: f};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word('{word: w, first: f});
    words_sent++;
  endtask

  // random file lead words by case
  function automatic logic [31:0] lead_word(int kind);
    logic [31:0] w;
    w = $urandom;
    case (kind)
      0: w = {8'($urandom_range(1, 4)), 24'h334449};
      1: begin
        case ($urandom_range(0, 3))
          0: w = 32'h072B504D;
          1: w = 32'h172B504D;
          2: w = 32'hF72B504D;
          default: w = 32'hFF2B504D;
        endcase
      end
      2: begin
        w[20:11] = 10'($urandom_range(4, 6));
        w[5:0] = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'd1;
      end
      3: w = ForeignMagic[$urandom_range(0, 11)];
      4: w = {8'($urandom), 24'h2B504D};
      5: w[15:0] = 16'h770B;
      default: ;
    endcase
    return w;
  endfunction

  // ID3 size words: marker bits mostly clear
  function automatic logic [31:0] id3_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 5) != 0) begin
      w[31] = 1'b0;
      w[23] = 1'b0;
      w[15] = 1'b0;
      w[7] = 1'b0;
    end
    return w;
  endfunction

  typedef struct {
    logic [31:0] word;
    logic        first;
    logic        has_ref;
    logic [3:0]  st;
  } stim_row_t;

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    int        kind, len;
    verdict_q = {};
    hp_done = 1'b1;
    hp_step = 0;
    hp_kind = KIND_NONE;
    hp_f = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: status typed in where obvious
    dir_rows = '{
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46},   // ignored while idle
      '{32'h00000000, 1'b1, 1'b1, STAT_NOT_MPC},
      '{32'hFFFFFFFF, 1'b1, 1'b1, STAT_NOT_MPC},
      '{32'h2043414D, 1'b1, 1'b1, STAT_FOREIGN},
      '{32'hBA010000, 1'b1, 1'b1, STAT_FOREIGN},
      '{32'h1234770B, 1'b1, 1'b1, STAT_FOREIGN},
      '{32'h202B504D, 1'b1, 1'b1, STAT_NEWER},
      '{32'h00002000, 1'b1, 1'b1, STAT_BLKSIZE},
      '{32'h01334449, 1'b1, 1'b0, STAT_SV46},
      '{32'h80000000, 1'b0, 1'b1, STAT_BAD_ID3},
      '{32'h04334449, 1'b1, 1'b0, STAT_SV46},
      '{32'h7F7F0001, 1'b0, 1'b0, STAT_SV46},
      '{32'h00007F7F, 1'b0, 1'b0, STAT_SV46},
      '{32'hFFC02001, 1'b1, 1'b0, STAT_SV46},
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46},
      '{32'h072B504D, 1'b1, 1'b0, STAT_SV46},
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46},
      '{32'h172B504D, 1'b1, 1'b0, STAT_SV46},  // restart mid header
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46},
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46},
      '{32'h00000000, 1'b0, 1'b0, STAT_SV46},
      '{32'h00000000, 1'b0, 1'b0, STAT_SV46},
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46},
      '{32'hFFFFFFFF, 1'b0, 1'b0, STAT_SV46}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.word, row.first);
      if (row.has_ref) begin
        if (verdict_q.size() == 0) begin
          $error("status: expected %0d got none, table row %0d", row.st, i);
          errors++;
        end else if (verdict_q[$].status != row.st) begin
          $error("status: expected %0d got %0d, table row %0d", row.st,
                 verdict_q[$].status, i);
          errors++;
        end
      end
    end

    // random files, mostly well formed
    while (words_sent < 1600) begin
      if (words_sent > 700 && words_sent < 760 && !hold_long) hold_long = 1'b1;
      kind = $urandom_range(0, 9);
      send_word(lead_word(kind), 1'b1);
      len = (kind == 1) ? 8 : (kind == 0 ? 2 : 1);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 9);
      for (int k = 0; k < len; k++)
        send_word(kind == 0 ? id3_word() : $urandom, 1'b0);
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d words; %0d verdicts checked across all header cases.",
             words_sent, verdicts_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // receiver stall, with one long hold-off
  initial begin
    int g;
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_long && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end
      g = gap_len();
      if (g == 0 || $urandom_range(0, 2) == 0) out_stall_i <= 1'b0;
      else begin
        out_stall_i <= 1'b1;
        repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    mpc_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict, status %0d", out_beat_o.status);
        errors++;
      end else begin
        e = verdict_q.pop_front();
        if (out_beat_o.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_beat_o.status); errors++; end
        if (out_beat_o.foreign_kind !== e.foreign_kind) begin
          $error("foreign_kind exp %0d got %0d", e.foreign_kind, out_beat_o.foreign_kind);
          errors++; end
        if (out_beat_o.stream_version !== e.stream_version) begin
          $error("stream_version exp %0d got %0d", e.stream_version,
                 out_beat_o.stream_version); errors++; end
        if (out_beat_o.total_frames !== e.total_frames) begin
          $error("total_frames exp %0h got %0h", e.total_frames, out_beat_o.total_frames);
          errors++; end
        if (out_beat_o.sample_rate !== e.sample_rate) begin
          $error("sample_rate exp %0d got %0d", e.sample_rate, out_beat_o.sample_rate);
          errors++; end
        if (out_beat_o.profile !== e.profile) begin
          $error("profile exp %0d got %0d", e.profile, out_beat_o.profile); errors++; end
        if (out_beat_o.encoder !== e.encoder) begin
          $error("encoder exp %0d got %0d", e.encoder, out_beat_o.encoder); errors++; end
        if (out_beat_o.coded_bitrate !== e.coded_bitrate) begin
          $error("coded_bitrate exp %0d got %0d", e.coded_bitrate, out_beat_o.coded_bitrate);
          errors++; end
        if (out_beat_o.max_band !== e.max_band) begin
          $error("max_band exp %0d got %0d", e.max_band, out_beat_o.max_band); errors++; end
        if (out_beat_o.stereo_modes !== e.stereo_modes) begin
          $error("stereo_modes exp %0d got %0d", e.stereo_modes, out_beat_o.stereo_modes);
          errors++; end
        if (out_beat_o.last_valid_samples !== e.last_valid_samples) begin
          $error("last_valid_samples exp %0d got %0d", e.last_valid_samples,
                 out_beat_o.last_valid_samples); errors++; end
        if (out_beat_o.skip_bytes !== e.skip_bytes) begin
          $error("skip_bytes exp %0d got %0d", e.skip_bytes, out_beat_o.skip_bytes);
          errors++; end
      end
    end
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
